// ----- rtl/fwtt_pkg.sv -----
// Shared types and constants for the four-way transposition table.
// Used by fwtt_bank and four_way_transposition_table_unit; no dependencies.
package fwtt_pkg;

  localparam int unsigned WAYS     = 4;
  localparam int unsigned BucketW  = 12;
  localparam logic [5:0]  MIN_DEPTH = 6'd2;
  localparam logic [6:0]  MOB_INIT  = 7'd64;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_STORE  = 1'b1;

  typedef struct packed {
    logic [63:0] mover;
    logic [63:0] other;
    logic [5:0]  depth;
    logic [63:0] moves;
    logic [63:0] passes;
    logic [63:0] wins;
    logic [63:0] draws;
    logic [63:0] losses;
    logic [6:0]  min_mob;
    logic [6:0]  max_mob;
  } entry_t;

  localparam entry_t ClearEntry = '{
    mover:   64'd0,
    other:   64'd0,
    depth:   6'd0,
    moves:   64'd0,
    passes:  64'd0,
    wins:    64'd0,
    draws:   64'd0,
    losses:  64'd0,
    min_mob: MOB_INIT,
    max_mob: 7'd0
  };

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_e;

endpackage

// ----- rtl/fwtt_bank.sv -----
// One bank of table entries: one write port, one read port, registered read.
// Depends on fwtt_pkg for the entry layout.
module fwtt_bank
  import fwtt_pkg::*;
#(
  parameter int unsigned RowW = 11,
  parameter int unsigned Rows = 1025
) (
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [RowW-1:0] rd_row_i,
  output entry_t          rd_data_o,
  input  logic            wr_en_i,
  input  logic [RowW-1:0] wr_row_i,
  input  entry_t          wr_data_i
);

  entry_t mem [Rows];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i] <= wr_data_i;
    end
  end

  // hold the last read until the next read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_row_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/four_way_transposition_table_unit.sv -----
// Four-way transposition table: lookups and stores over a four-entry window.
// Each item is accepted with its bank read, then evaluated and written back;
// the evaluate state waits until the output register can take its result.
// The next item is accepted only after the write-back. Reset: counters clear
// at once; a clearing pass then writes every bank row, with input stalled.
module four_way_transposition_table_unit
  import fwtt_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [11:0] bucket_index_i,
  input  logic [63:0] mover_bits_i,
  input  logic [63:0] other_bits_i,
  input  logic [5:0]  remaining_depth_i,
  input  logic [63:0] in_moves_i,
  input  logic [63:0] in_passes_i,
  input  logic [63:0] in_wins_i,
  input  logic [63:0] in_draws_i,
  input  logic [63:0] in_losses_i,
  input  logic [6:0]  in_min_mobility_i,
  input  logic [6:0]  in_max_mobility_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [63:0] out_moves_o,
  output logic [63:0] out_passes_o,
  output logic [63:0] out_wins_o,
  output logic [63:0] out_draws_o,
  output logic [63:0] out_losses_o,
  output logic [6:0]  out_min_mobility_o,
  output logic [6:0]  out_max_mobility_o,
  output logic [63:0] probe_total_o,
  output logic [63:0] hit_total_o
);

  // Entry k lives in bank k[1:0], row k >> 2. Any window of four consecutive
  // entries touches each bank exactly once, so one read fetches it all.
  // The three entries past the top of the index range land in the extra row.
  localparam int unsigned RowW  = INDEX_BITS - 1;
  localparam int unsigned Rows  = (2 ** (INDEX_BITS - 2)) + 1;
  localparam int unsigned CopyW = (INDEX_BITS < BucketW) ? INDEX_BITS : BucketW;
  localparam logic [RowW-1:0] LastRow = RowW'(Rows - 1);

  state_e state_q, state_d;

  logic in_beat;
  logic eval_busy;
  logic clearing;
  logic out_free;
  logic done;

  // Item captured at the accept beat.
  logic            kind_q;
  logic [1:0]      lo_q;
  logic [RowW-1:0] row_q [WAYS];
  entry_t          item_q;

  logic [INDEX_BITS-1:0] base;
  logic [RowW-1:0]       row_in [WAYS];

  logic [RowW-1:0] clr_row_q, clr_row_d;

  entry_t          rd_data [WAYS];
  logic            wr_en   [WAYS];
  logic [RowW-1:0] wr_row  [WAYS];
  entry_t          wr_data;

  entry_t     slot [WAYS];
  logic [WAYS-1:0] match;
  logic       act;
  logic       is_lookup;
  logic       is_store;
  logic       hit_any;
  logic [1:0] hit_slot;
  logic [1:0] p01, p23, pick;
  logic [63:0] m01, m23;
  logic [1:0] wr_bank;

  logic [63:0] lookup_cnt_q, lookup_cnt_d;
  logic [63:0] hit_cnt_q, hit_cnt_d;

  logic        out_valid_q, out_valid_d;
  logic        hit_q;
  logic [63:0] moves_q, passes_q, wins_q, draws_q, losses_q;
  logic [6:0]  min_mob_q, max_mob_q;
  logic [63:0] probe_total_q, hit_total_q;

  // ---------------------------------------------------------------------------
  // Control: clear the banks, then alternate accept and evaluate.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_row_q == LastRow) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // stay until the output register can take the result
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    eval_busy  = 1'b0;
    clearing   = 1'b0;
    case (state_q)
      ST_CLEAR: clearing   = 1'b1;
      ST_IDLE:  in_stall_o = 1'b0;
      ST_EVAL:  eval_busy  = 1'b1;
      default:  clearing   = 1'b0;
    endcase
  end

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign done     = eval_busy && out_free;

  assign clr_row_d = clearing ? (clr_row_q + RowW'(1)) : clr_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_row_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_row_q <= clr_row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Address the window: bank b serves row base>>2, or the next row when b
  // falls below the base's low bits (the window has wrapped past bank 3).
  // ---------------------------------------------------------------------------
  always_comb begin
    base = '0;
    base[CopyW-1:0] = bucket_index_i[CopyW-1:0];
    for (int b = 0; b < WAYS; b++) begin
      row_in[b] = RowW'(base >> 2) + RowW'(2'(b) < base[1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      kind_q         <= kind_i;
      lo_q           <= base[1:0];
      row_q          <= row_in;
      item_q.mover   <= mover_bits_i;
      item_q.other   <= other_bits_i;
      item_q.depth   <= remaining_depth_i;
      item_q.moves   <= in_moves_i;
      item_q.passes  <= in_passes_i;
      item_q.wins    <= in_wins_i;
      item_q.draws   <= in_draws_i;
      item_q.losses  <= in_losses_i;
      item_q.min_mob <= in_min_mobility_i;
      item_q.max_mob <= in_max_mobility_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Banks. The read is issued on the accept beat; the write-back happens when
  // the evaluate state completes, before the next item can be accepted, so
  // a following read always sees the updated entry.
  // ---------------------------------------------------------------------------
  assign wr_data = clearing ? ClearEntry : item_q;

  for (genvar b = 0; b < WAYS; b++) begin : g_bank
    assign wr_en[b]  = clearing || (done && is_store && (wr_bank == 2'(b)));
    assign wr_row[b] = clearing ? clr_row_q : row_q[b];

    fwtt_bank #(
      .RowW (RowW),
      .Rows (Rows)
    ) u_bank (
      .clk_i     (clk_i),
      .rd_en_i   (in_beat),
      .rd_row_i  (row_in[b]),
      .rd_data_o (rd_data[b]),
      .wr_en_i   (wr_en[b]),
      .wr_row_i  (wr_row[b]),
      .wr_data_i (wr_data)
    );
  end

  // ---------------------------------------------------------------------------
  // Evaluate: rotate banks into window order, match for lookups, pick the
  // victim for stores.
  // ---------------------------------------------------------------------------
  assign act       = item_q.depth > MIN_DEPTH;
  assign is_lookup = act && (kind_q == KIND_LOOKUP);
  assign is_store  = act && (kind_q == KIND_STORE);

  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      slot[j]  = rd_data[2'(lo_q + 2'(j))];
      match[j] = (slot[j].depth == item_q.depth) &&
                 (slot[j].mover == item_q.mover) &&
                 (slot[j].other == item_q.other);
    end
  end

  // first matching slot wins
  always_comb begin
    hit_any  = |match;
    hit_slot = 2'd3;
    if (match[2]) hit_slot = 2'd2;
    if (match[1]) hit_slot = 2'd1;
    if (match[0]) hit_slot = 2'd0;
  end

  // Smallest move count, lowest slot on a tie: a pairwise tree that keeps the
  // left side unless the right side is strictly smaller.
  always_comb begin
    p01  = (slot[0].moves > slot[1].moves) ? 2'd1 : 2'd0;
    m01  = (slot[0].moves > slot[1].moves) ? slot[1].moves : slot[0].moves;
    p23  = (slot[2].moves > slot[3].moves) ? 2'd3 : 2'd2;
    m23  = (slot[2].moves > slot[3].moves) ? slot[3].moves : slot[2].moves;
    pick = (m01 > m23) ? p23 : p01;
  end

  assign wr_bank = lo_q + pick;

  assign lookup_cnt_d = lookup_cnt_q + {63'd0, is_lookup};
  assign hit_cnt_d    = hit_cnt_q + {63'd0, (is_lookup && hit_any)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lookup_cnt_q <= '0;
      hit_cnt_q    <= '0;
    end else if (done) begin
      lookup_cnt_q <= lookup_cnt_d;
      hit_cnt_q    <= hit_cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: load on done, drop the beat once it is taken.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      probe_total_q <= lookup_cnt_d;
      hit_total_q   <= hit_cnt_d;
      if (is_lookup && hit_any) begin
        hit_q     <= 1'b1;
        moves_q   <= slot[hit_slot].moves;
        passes_q  <= slot[hit_slot].passes;
        wins_q    <= slot[hit_slot].wins;
        draws_q   <= slot[hit_slot].draws;
        losses_q  <= slot[hit_slot].losses;
        min_mob_q <= slot[hit_slot].min_mob;
        max_mob_q <= slot[hit_slot].max_mob;
      end else begin
        hit_q     <= 1'b0;
        moves_q   <= '0;
        passes_q  <= '0;
        wins_q    <= '0;
        draws_q   <= '0;
        losses_q  <= '0;
        min_mob_q <= MOB_INIT;
        max_mob_q <= '0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign hit_o              = hit_q;
  assign out_moves_o        = moves_q;
  assign out_passes_o       = passes_q;
  assign out_wins_o         = wins_q;
  assign out_draws_o        = draws_q;
  assign out_losses_o       = losses_q;
  assign out_min_mobility_o = min_mob_q;
  assign out_max_mobility_o = max_mob_q;
  assign probe_total_o      = probe_total_q;
  assign hit_total_o        = hit_total_q;

endmodule
